[src/rsw_pkg.sv]
// Running statistics package: widths, controller states, command and status types.
package rsw_pkg;

  localparam int unsigned SampleWidth = 32;
  localparam int unsigned CountCap    = 16384;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CntW      = 15;
  localparam int unsigned MeanW     = 48;
  localparam int unsigned DiffW     = MeanW + 1;
  localparam int unsigned DevW      = 64;
  localparam int unsigned StdW      = 31;
  localparam int unsigned RootW     = DevW / 2;
  localparam int unsigned ProdW     = 2 * DiffW - 1;
  localparam int unsigned FracShift = 16;
  localparam int unsigned DivRemW   = CntW;
  localparam int unsigned DivStepW  = 7;
  localparam int unsigned SqrtStepW = 6;
  localparam int unsigned HalfW     = 32;

  localparam logic [DivStepW-1:0]  DivMeanSteps = DivStepW'(DiffW);
  localparam logic [DivStepW-1:0]  DivStdSteps  = DivStepW'(DevW);
  localparam logic [SqrtStepW-1:0] SqrtSteps    = SqrtStepW'(RootW);
  localparam logic [CntW-1:0]      CountCapVal  = CntW'(CountCap);

  localparam logic [1:0] MulLoLo = 2'd0;
  localparam logic [1:0] MulLoHi = 2'd1;
  localparam logic [1:0] MulHiLo = 2'd2;
  localparam logic [1:0] MulHiHi = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StDivMeanGo,
    StDivMeanWait,
    StMeanUpd,
    StDev2,
    StMul0,
    StMul1,
    StMul2,
    StMul3,
    StMulAcc,
    StDevUpd,
    StDivStdGo,
    StDivStdWait,
    StSqrtGo,
    StSqrtWait,
    StOutput
  } rsw_state_e;

  typedef struct packed {
    logic       load;
    logic       div_mean_go;
    logic       mean_upd;
    logic       mag2_upd;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_clr;
    logic       acc_en;
    logic       dev_upd;
    logic       div_std_go;
    logic       sqrt_go;
    logic       out_load;
  } rsw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic cnt_gt1;
  } rsw_status_t;

endpackage

[src/rsw_in_if.sv]
// Input channel interface: one sample word per handshake.
interface rsw_in_if;
  logic                          valid;
  logic                          ready;
  logic [rsw_pkg::DataW-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[src/rsw_out_if.sv]
// Result channel interface: one statistics word per handshake.
interface rsw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rsw_pkg::DataW-1:0]     min_value;
  logic [rsw_pkg::DataW-1:0]     max_value;
  logic [rsw_pkg::DataW-1:0]     mean_value;
  logic [rsw_pkg::StdW-1:0]      std_value;
  logic [rsw_pkg::CntW-1:0]      sample_count;

  modport source (output valid, output min_value, output max_value, output mean_value,
                  output std_value, output sample_count, input ready);
  modport sink   (input valid, input min_value, input max_value, input mean_value,
                  input std_value, input sample_count, output ready);
endinterface

[src/rsw_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned 64-bit dividend by count.
module rsw_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rsw_pkg::DevW-1:0]        dividend_i,
  input  logic [rsw_pkg::CntW-1:0]        divisor_i,
  input  logic [rsw_pkg::DivStepW-1:0]    steps_i,
  output logic                            done_o,
  output logic [rsw_pkg::DevW-1:0]        quotient_o
);

  logic [rsw_pkg::DevW-1:0]     work_q;
  logic [rsw_pkg::DivRemW-1:0]  rem_q;
  logic [rsw_pkg::CntW-1:0]     dsr_q;
  logic [rsw_pkg::DivStepW-1:0] left_q;
  logic                         done_q;
  logic [rsw_pkg::DivRemW:0]    rem_sh;
  logic [rsw_pkg::DivRemW:0]    rem_nx;
  logic                         fits;

  always_comb begin
    rem_sh = {rem_q, work_q[rsw_pkg::DevW-1]};
    fits   = (rem_sh >= {1'b0, dsr_q});
    rem_nx = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      left_q <= steps_i;
      done_q <= 1'b0;
    end else if (left_q != '0) begin
      left_q <= left_q - 1'b1;
      done_q <= (left_q == rsw_pkg::DivStepW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (left_q != '0) begin
      work_q <= {work_q[rsw_pkg::DevW-2:0], fits};
      rem_q  <= rem_nx[rsw_pkg::DivRemW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

[src/rsw_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module rsw_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rsw_pkg::DevW-1:0]     radicand_i,
  output logic                         done_o,
  output logic [rsw_pkg::RootW-1:0]    root_o
);

  logic [rsw_pkg::DevW-1:0]      v_q;
  logic [rsw_pkg::RootW:0]       rem_q;
  logic [rsw_pkg::RootW-1:0]     root_q;
  logic [rsw_pkg::SqrtStepW-1:0] left_q;
  logic                          done_q;
  logic [rsw_pkg::RootW+2:0]     rem_sh;
  logic [rsw_pkg::RootW+2:0]     trial;
  logic [rsw_pkg::RootW+2:0]     rem_nx;
  logic                          fits;

  always_comb begin
    rem_sh = {rem_q, v_q[rsw_pkg::DevW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = (rem_sh >= trial);
    rem_nx = fits ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      left_q <= rsw_pkg::SqrtSteps;
      done_q <= 1'b0;
    end else if (left_q != '0) begin
      left_q <= left_q - 1'b1;
      done_q <= (left_q == rsw_pkg::SqrtStepW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (left_q != '0) begin
      v_q    <= {v_q[rsw_pkg::DevW-3:0], 2'b00};
      rem_q  <= rem_nx[rsw_pkg::RootW:0];
      root_q <= {root_q[rsw_pkg::RootW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[src/rsw_datapath.sv]
// Datapath: statistics state, shared divider, square root and partial-product multiplier.
module rsw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsw_pkg::rsw_cmd_t           cmd_i,
  output rsw_pkg::rsw_status_t        status_o,
  input  logic [rsw_pkg::DataW-1:0]   sample_i,
  output logic [rsw_pkg::DataW-1:0]   min_value_o,
  output logic [rsw_pkg::DataW-1:0]   max_value_o,
  output logic [rsw_pkg::DataW-1:0]   mean_value_o,
  output logic [rsw_pkg::StdW-1:0]    std_value_o,
  output logic [rsw_pkg::CntW-1:0]    sample_count_o
);

  localparam int unsigned DataW = rsw_pkg::DataW;
  localparam int unsigned MeanW = rsw_pkg::MeanW;
  localparam int unsigned DiffW = rsw_pkg::DiffW;
  localparam int unsigned DevW  = rsw_pkg::DevW;
  localparam int unsigned ProdW = rsw_pkg::ProdW;
  localparam int unsigned HalfW = rsw_pkg::HalfW;
  localparam int unsigned FracShift = rsw_pkg::FracShift;

  logic [DataW-1:0]  x_q, min_q, max_q;
  logic [MeanW-1:0]  mean_q;
  logic [DevW-1:0]   dev_q;
  logic [rsw_pkg::CntW-1:0] cnt_q;
  logic              neg1_q;
  logic [DiffW-1:0]  mag1_q, mag2_q;
  logic [ProdW-1:0]  pp_q, acc_q;

  logic [DataW-1:0]  min_out_q, max_out_q, mean_out_q;
  logic [rsw_pkg::StdW-1:0] std_out_q;
  logic [rsw_pkg::CntW-1:0] cnt_out_q;

  logic [DataW-1:0]  x_new;
  logic [MeanW-1:0]  big;
  logic [DiffW-1:0]  diff, dmag, quo, q_signed, mean_sum, rnd;
  logic [DataW:0]    mo;
  logic [DataW-1:0]  mean_sat;
  logic [HalfW-1:0]  op_a, op_b;
  logic [2*HalfW-1:0] prod;
  logic [ProdW-1:0]  prod_sh;
  logic [DevW-1:0]   inc;
  logic [DevW:0]     dev_sum;
  logic [rsw_pkg::StdW-1:0] std_sat;

  logic              div_start, div_done;
  logic [DevW-1:0]   div_dividend, div_quo;
  logic [rsw_pkg::DivStepW-1:0] div_steps;
  logic              sqrt_done;
  logic [rsw_pkg::RootW-1:0] root;

  always_comb begin
    x_new = DataW'($signed(sample_i[rsw_pkg::SampleWidth-1:0]));
    big   = {x_q, {FracShift{1'b0}}};
    // The same difference serves before the mean update (d1) and after it (d2).
    diff  = {big[MeanW-1], big} - {mean_q[MeanW-1], mean_q};
    dmag  = diff[DiffW-1] ? (~diff + 1'b1) : diff;
    quo      = div_quo[DiffW-1:0];
    q_signed = neg1_q ? (~quo + 1'b1) : quo;
    mean_sum = {mean_q[MeanW-1], mean_q} + q_signed;

    // Round half up, then saturate to the 32-bit output range.
    rnd = {mean_q[MeanW-1], mean_q} + DiffW'(32'd1 << (FracShift - 1));
    mo  = rnd[DiffW-1 -: DataW+1];
    if (mo[DataW] != mo[DataW-1]) begin
      mean_sat = mo[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      mean_sat = mo[DataW-1:0];
    end

    op_a = cmd_i.mul_sel[1] ? HalfW'(mag1_q[DiffW-1:HalfW]) : mag1_q[HalfW-1:0];
    op_b = cmd_i.mul_sel[0] ? HalfW'(mag2_q[DiffW-1:HalfW]) : mag2_q[HalfW-1:0];
    prod = op_a * op_b;
    case (cmd_i.mul_sel)
      rsw_pkg::MulLoLo: prod_sh = ProdW'(prod);
      rsw_pkg::MulHiHi: prod_sh = ProdW'(prod) << (2 * HalfW);
      default:          prod_sh = ProdW'(prod) << HalfW;
    endcase

    inc     = acc_q[ProdW-1] ? {DevW{1'b1}} : acc_q[ProdW-2 -: DevW];
    dev_sum = {1'b0, dev_q} + {1'b0, inc};

    std_sat = root[rsw_pkg::RootW-1] ? {rsw_pkg::StdW{1'b1}} : root[rsw_pkg::StdW-1:0];

    div_start    = cmd_i.div_mean_go | cmd_i.div_std_go;
    div_dividend = cmd_i.div_std_go ? dev_q : {dmag, {(DevW-DiffW){1'b0}}};
    div_steps    = cmd_i.div_std_go ? rsw_pkg::DivStdSteps : rsw_pkg::DivMeanSteps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= {1'b0, {(DataW-1){1'b1}}};
      max_q  <= {1'b1, {(DataW-1){1'b0}}};
      mean_q <= '0;
      dev_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        if ($signed(x_new) < $signed(min_q)) min_q <= x_new;
        if ($signed(x_new) > $signed(max_q)) max_q <= x_new;
        if (cnt_q < rsw_pkg::CountCapVal) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.mean_upd) mean_q <= mean_sum[MeanW-1:0];
      if (cmd_i.dev_upd)  dev_q  <= dev_sum[DevW] ? {DevW{1'b1}} : dev_sum[DevW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) x_q <= x_new;
    if (cmd_i.div_mean_go) begin
      neg1_q <= diff[DiffW-1];
      mag1_q <= dmag;
    end
    if (cmd_i.mag2_upd) mag2_q <= dmag;
    if (cmd_i.mul_en)   pp_q   <= prod_sh;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + pp_q;
    end
    if (cmd_i.out_load) begin
      min_out_q  <= min_q;
      max_out_q  <= max_q;
      mean_out_q <= mean_sat;
      std_out_q  <= status_o.cnt_gt1 ? std_sat : '0;
      cnt_out_q  <= cnt_q;
    end
  end

  rsw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rsw_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_go),
    .radicand_i (div_quo),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_comb begin
    status_o.div_done  = div_done;
    status_o.sqrt_done = sqrt_done;
    status_o.cnt_gt1   = (cnt_q > rsw_pkg::CntW'(1));
  end

  assign min_value_o    = min_out_q;
  assign max_value_o    = max_out_q;
  assign mean_value_o   = mean_out_q;
  assign std_value_o    = std_out_q;
  assign sample_count_o = cnt_out_q;

endmodule

[src/rsw_ctrl.sv]
// Controller: sequences the datapath for one sample and owns the handshakes.
module rsw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  rsw_pkg::rsw_status_t  status_i,
  output rsw_pkg::rsw_cmd_t     cmd_o
);

  rsw_pkg::rsw_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rsw_pkg::StIdle:        if (in_valid_i) state_d = rsw_pkg::StDivMeanGo;
      rsw_pkg::StDivMeanGo:   state_d = rsw_pkg::StDivMeanWait;
      rsw_pkg::StDivMeanWait: if (status_i.div_done) state_d = rsw_pkg::StMeanUpd;
      rsw_pkg::StMeanUpd:     state_d = rsw_pkg::StDev2;
      rsw_pkg::StDev2:        state_d = rsw_pkg::StMul0;
      rsw_pkg::StMul0:        state_d = rsw_pkg::StMul1;
      rsw_pkg::StMul1:        state_d = rsw_pkg::StMul2;
      rsw_pkg::StMul2:        state_d = rsw_pkg::StMul3;
      rsw_pkg::StMul3:        state_d = rsw_pkg::StMulAcc;
      rsw_pkg::StMulAcc:      state_d = rsw_pkg::StDevUpd;
      rsw_pkg::StDevUpd: begin
        state_d = status_i.cnt_gt1 ? rsw_pkg::StDivStdGo : rsw_pkg::StOutput;
      end
      rsw_pkg::StDivStdGo:    state_d = rsw_pkg::StDivStdWait;
      rsw_pkg::StDivStdWait:  if (status_i.div_done) state_d = rsw_pkg::StSqrtGo;
      rsw_pkg::StSqrtGo:      state_d = rsw_pkg::StSqrtWait;
      rsw_pkg::StSqrtWait:    if (status_i.sqrt_done) state_d = rsw_pkg::StOutput;
      rsw_pkg::StOutput:      if (out_free) state_d = rsw_pkg::StIdle;
      default:                state_d = rsw_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rsw_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rsw_pkg::StDivMeanGo: cmd_o.div_mean_go = 1'b1;
      rsw_pkg::StMeanUpd:   cmd_o.mean_upd = 1'b1;
      rsw_pkg::StDev2:      cmd_o.mag2_upd = 1'b1;
      rsw_pkg::StMul0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rsw_pkg::MulLoLo;
        cmd_o.acc_clr = 1'b1;
      end
      rsw_pkg::StMul1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rsw_pkg::MulLoHi;
        cmd_o.acc_en  = 1'b1;
      end
      rsw_pkg::StMul2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rsw_pkg::MulHiLo;
        cmd_o.acc_en  = 1'b1;
      end
      rsw_pkg::StMul3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rsw_pkg::MulHiHi;
        cmd_o.acc_en  = 1'b1;
      end
      rsw_pkg::StMulAcc:   cmd_o.acc_en = 1'b1;
      rsw_pkg::StDevUpd:   cmd_o.dev_upd = 1'b1;
      rsw_pkg::StDivStdGo: cmd_o.div_std_go = 1'b1;
      rsw_pkg::StSqrtGo:   cmd_o.sqrt_go = 1'b1;
      rsw_pkg::StOutput:   cmd_o.out_load = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A new word replaces a taken one in the same cycle, so valid stays high.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsw_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/running_stats_welford_unit.sv]
// Top level of the running statistics unit: controller plus datapath.
//
// Usage: samples arrive on in_i, one signed Q16.16 word per valid/ready
// handshake. Each sample yields exactly one word on out_o carrying the
// running minimum, maximum, rounded mean, population standard deviation
// and the sample count, which saturates at 16384.
// Each sample passes through the mean division, the mean update, the
// partial-product multiply and the deviation update; while the count is at
// most one, the deviation division and the square root are skipped, else
// the shared one-bit-per-cycle divider (49 steps for the mean update, 64 for
// the variance) and the 32-step square root unit follow.
// in_i.ready is high only while the controller is idle, so the next sample
// is taken only once the last one has left the output state.
// A finished word waits in the output register; the unit still accepts and
// processes the next sample, and holds its result until the earlier word is
// taken, so a stalled receiver loses nothing.
// Reset clears the statistics: min to the most positive value, max to the
// most negative, mean, deviation sum and count to zero; out_o.valid drops.
module running_stats_welford_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsw_in_if.sink     in_i,
  rsw_out_if.source  out_o
);

  rsw_pkg::rsw_cmd_t    cmd;
  rsw_pkg::rsw_status_t status;

  rsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rsw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (in_i.sample),
    .min_value_o    (out_o.min_value),
    .max_value_o    (out_o.max_value),
    .mean_value_o   (out_o.mean_value),
    .std_value_o    (out_o.std_value),
    .sample_count_o (out_o.sample_count)
  );

endmodule

[test/running_stats_welford_unit_test.sv]
// Self-checking testbench for the running statistics unit: table-driven and random samples.
`timescale 1ns / 1ps

module running_stats_welford_unit_test;

  localparam int unsigned RandomItems = 1300;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned SettleWait  = 200;
  localparam longint      CycleLimit  = 20_000_000;

  // Fields of a table row whose value is typed in rather than predicted.
  localparam logic [4:0] FixMin  = 5'b10000;
  localparam logic [4:0] FixMax  = 5'b01000;
  localparam logic [4:0] FixMean = 5'b00100;
  localparam logic [4:0] FixStd  = 5'b00010;
  localparam logic [4:0] FixCnt  = 5'b00001;
  localparam logic [4:0] FixNone = 5'b00000;
  localparam logic [4:0] FixAll  = FixMin | FixMax | FixMean | FixStd | FixCnt;

  localparam logic [rsw_pkg::DataW-1:0] MostPos = 32'h7FFF_FFFF;
  localparam logic [rsw_pkg::DataW-1:0] MostNeg = 32'h8000_0000;

  typedef struct packed {
    logic [rsw_pkg::DataW-1:0] min_v;
    logic [rsw_pkg::DataW-1:0] max_v;
    logic [rsw_pkg::DataW-1:0] mean_v;
    logic [rsw_pkg::StdW-1:0]  std_v;
    logic [rsw_pkg::CntW-1:0]  cnt;
  } stats_t;

  typedef struct {
    logic [rsw_pkg::DataW-1:0] sample;
    logic [4:0]                fixed;
    stats_t                    want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rsw_in_if  in_ch ();
  rsw_out_if out_ch ();

  running_stats_welford_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, mirrors the unit's statistics registers.
  logic signed [rsw_pkg::DataW-1:0] lo_q;
  logic signed [rsw_pkg::DataW-1:0] hi_q;
  logic signed [63:0]               mean_q;
  logic [63:0]                      dev_q;
  logic [rsw_pkg::CntW-1:0]         cnt_q;

  stats_t      due_stats_q[$];
  row_t        rows[$];
  int unsigned open_rows;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_fail;
  longint      n_cycles;
  bit          quiet;

  // Stimulus shaping: a window around a center that wanders and widens.
  int unsigned               span;
  int                        center;
  logic [rsw_pkg::DataW-1:0] last_s;

  function automatic stats_t track_sample(input logic [rsw_pkg::DataW-1:0] s);
    logic signed [rsw_pkg::SampleWidth-1:0] xs;
    logic signed [63:0] x, big, d1, d2, rnd, mo, div;
    logic [63:0] m1, m2, inc, v, ucnt, root, trial;
    logic [127:0] prod;
    logic [64:0] sum;
    stats_t r;
    xs = s[rsw_pkg::SampleWidth-1:0];
    x = xs;
    if (x < lo_q) lo_q = xs;
    if (x > hi_q) hi_q = xs;
    if (cnt_q < rsw_pkg::CountCapVal) cnt_q = cnt_q + 1'b1;
    div = '0;
    div[rsw_pkg::CntW-1:0] = cnt_q;
    ucnt = div;

    big = x * 64'sd65536;
    d1 = big - mean_q;
    mean_q = mean_q + d1 / div;
    d2 = big - mean_q;
    m1 = (d1 < 0) ? -d1 : d1;
    m2 = (d2 < 0) ? -d2 : d2;
    prod = {64'd0, m1} * {64'd0, m2};
    inc = (prod[127:96] != '0) ? '1 : prod[95:32];
    sum = {1'b0, dev_q} + {1'b0, inc};
    dev_q = sum[64] ? '1 : sum[63:0];

    // Rounding adds half an LSB and floors, so ties go toward plus infinity.
    rnd = mean_q + 64'sd32768;
    mo = rnd >>> 16;
    if (mo > 64'sh7FFF_FFFF) mo = 64'sh7FFF_FFFF;
    if (mo < -64'sh8000_0000) mo = -64'sh8000_0000;

    root = '0;
    if (cnt_q > 1) begin
      v = dev_q / ucnt;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
    end

    r.min_v  = lo_q;
    r.max_v  = hi_q;
    r.mean_v = mo[rsw_pkg::DataW-1:0];
    r.std_v  = root[rsw_pkg::StdW-1:0];
    r.cnt    = cnt_q;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 300);
  endfunction

  function automatic logic [rsw_pkg::DataW-1:0] pick_sample();
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) return last_s;
    if (r < 10) v = int'($urandom_range(0, 4 * span)) - int'(2 * span);
    else v = int'($urandom_range(0, 2 * span)) - int'(span);
    last_s = center + v;
    return last_s;
  endfunction

  function automatic void add_row(input logic [rsw_pkg::DataW-1:0] s, input logic [4:0] fixed,
                                  input logic [rsw_pkg::DataW-1:0] mn,
                                  input logic [rsw_pkg::DataW-1:0] mx,
                                  input logic [rsw_pkg::DataW-1:0] mean,
                                  input logic [rsw_pkg::StdW-1:0] sd,
                                  input logic [rsw_pkg::CntW-1:0] c);
    row_t r;
    r.sample = s;
    r.fixed  = fixed;
    r.want   = {mn, mx, mean, sd, c};
    rows.push_back(r);
  endfunction

  task automatic send_word(input logic [rsw_pkg::DataW-1:0] s, input logic [4:0] fixed,
                           input stats_t want);
    stats_t e;
    int unsigned gap;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    e = track_sample(s);
    if (fixed[4]) e.min_v = want.min_v;
    if (fixed[3]) e.max_v = want.max_v;
    if (fixed[2]) e.mean_v = want.mean_v;
    if (fixed[1]) e.std_v = want.std_v;
    if (fixed[0]) e.cnt = want.cnt;
    due_stats_q.push_back(e);
    n_accepted++;
    gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_rows(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i < last; i++) begin
      send_word(rows[i].sample, rows[i].fixed, rows[i].want);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_stats_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_fail(input string what);
    if (n_fail < ReportMax) $display("ERROR at %0t: %s", $realtime, what);
    n_fail++;
  endtask

  task automatic check_word();
    stats_t e;
    if (due_stats_q.size() == 0) begin
      note_fail("result word arrived with no expectation pending");
      return;
    end
    e = due_stats_q.pop_front();
    if (out_ch.min_value !== e.min_v)
      note_fail($sformatf("word %0d min_value: expected %h, got %h",
                          n_checked, e.min_v, out_ch.min_value));
    if (out_ch.max_value !== e.max_v)
      note_fail($sformatf("word %0d max_value: expected %h, got %h",
                          n_checked, e.max_v, out_ch.max_value));
    if (out_ch.mean_value !== e.mean_v)
      note_fail($sformatf("word %0d mean_value: expected %h, got %h",
                          n_checked, e.mean_v, out_ch.mean_value));
    if (out_ch.std_value !== e.std_v)
      note_fail($sformatf("word %0d std_value: expected %h, got %h",
                          n_checked, e.std_v, out_ch.std_value));
    if (out_ch.sample_count !== e.cnt)
      note_fail($sformatf("word %0d sample_count: expected %0d, got %0d",
                          n_checked, e.cnt, out_ch.sample_count));
    n_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) check_word();
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d words pending.",
               n_cycles, due_stats_q.size());
      $display("running_stats_welford_unit_test: FAIL");
      $finish;
    end
  end

  // The receiver takes words in bursts and stalls at random in between.
  initial begin : rx_pacing
    int unsigned len;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ch.ready <= 1'b1;
      len = $urandom_range(1, 24);
      repeat (len) @(posedge clk_i);
      len = idle_len();
      if (len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    stats_t none;
    int unsigned shift;
    none = '0;
    n_cycles = 0;
    n_accepted = 0;
    n_checked = 0;
    n_fail = 0;
    quiet = 1'b0;
    span = 256;
    center = 0;
    last_s = '0;
    lo_q = MostPos;
    hi_q = MostNeg;
    mean_q = '0;
    dev_q = '0;
    cnt_q = '0;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;

    // Opening table: identical first samples give zero spread, then small values
    // around zero probe mean rounding on both sides of a half LSB.
    add_row(32'h0001_8000, FixAll, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, '0, 15'd1);
    add_row(32'h0001_8000, FixAll, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, '0, 15'd2);
    add_row(32'hFFFF_8000, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0001_8000, '0, '0, 15'd3);
    add_row(32'h0000_0001, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0001_8000, '0, '0, 15'd4);
    add_row(32'hFFFF_FFFF, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0001_8000, '0, '0, 15'd5);
    add_row(32'h0000_0002, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0001_8000, '0, '0, 15'd6);
    add_row(32'hFFFF_FFFE, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0001_8000, '0, '0, 15'd7);
    add_row(32'h0000_0000, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0001_8000, '0, '0, 15'd8);
    add_row(32'h0010_0000, FixMin | FixMax | FixCnt, 32'hFFFF_8000, 32'h0010_0000, '0, '0, 15'd9);
    add_row(32'hFFF0_0000, FixMin | FixMax | FixCnt, 32'hFFF0_0000, 32'h0010_0000, '0, '0, 15'd10);
    add_row(32'h0000_7FFF, FixMin | FixMax | FixCnt, 32'hFFF0_0000, 32'h0010_0000, '0, '0, 15'd11);
    add_row(32'hFFFF_8001, FixMin | FixMax | FixCnt, 32'hFFF0_0000, 32'h0010_0000, '0, '0, 15'd12);
    add_row(32'h00A5_5A5A, FixMin | FixMax | FixCnt, 32'hFFF0_0000, 32'h00A5_5A5A, '0, '0, 15'd13);
    add_row(32'hFF5A_A5A5, FixMin | FixMax | FixCnt, 32'hFF5A_A5A5, 32'h00A5_5A5A, '0, '0, 15'd14);
    open_rows = rows.size();

    // Closing table: full-scale samples pin min and max for good and drive the
    // deviation sum into saturation, so they only come at the end.
    add_row(MostNeg, FixMin, MostNeg, '0, '0, '0, '0);
    for (int k = 0; k < 9; k++) begin
      add_row(k[0] ? MostNeg : MostPos, FixMin | FixMax,
              MostNeg, MostPos, '0, '0, '0);
    end
    add_row(32'h0000_0000, FixMin | FixMax, MostNeg, MostPos, '0, '0, '0);
    add_row(32'hFFFF_FFFF, FixMin | FixMax, MostNeg, MostPos, '0, '0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_rows(0, open_rows);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      shift = (i * 16) / RandomItems;
      span = 256 << shift;
      if (i % 100 == 0) center = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      quiet = (i >= 600 && i < 680);
      send_word(pick_sample(), FixNone, none);
      if (i % 450 == 449) drain_results();
    end

    run_rows(open_rows, rows.size());
    drain_results();
    repeat (SettleWait) @(posedge clk_i);

    $display("Sent %0d samples and compared %0d result words; the count reached %0d.",
             n_accepted, n_checked, cnt_q);
    $display("The deviation sum %s saturated; %0d field mismatches were seen.",
             (dev_q == '1) ? "was" : "was not", n_fail);
    if (n_fail == 0 && due_stats_q.size() == 0) begin
      $display("running_stats_welford_unit_test: PASS");
    end else begin
      $display("running_stats_welford_unit_test: FAIL");
    end
    $finish;
  end

endmodule
